// ===== hw/rtl/lghd_pkg.sv =====
`timescale 1ns / 1ps

package lghd_pkg;

  typedef enum logic [2:0] {
    ACT_PIXEL   = 3'd0,
    ACT_SEGMENT = 3'd1,
    ACT_FRAME   = 3'd2,
    ACT_STROBE  = 3'd3,
    ACT_READ    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CFG_SERIAL_MODE = 2'd0,
    CFG_PAL_TIMING  = 2'd1,
    CFG_BRIGHT_MASK = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned TS_W   = 32;

  // master clock sum shifted down by 16, left to divide by 3
  localparam int unsigned TDIV_W = TS_W - 3;
  localparam logic [31:0] DIV3_MUL = 32'hAAAA_AAAB;
  localparam int unsigned DIV3_SHIFT = 33;
  localparam int unsigned PROD_W = TDIV_W + 32;

  localparam logic [3:0] SER_IDX_ID    = 4'd4;
  localparam logic [3:0] SER_IDX_LIGHT = 4'd6;
  localparam logic [3:0] SER_IDX_TRIG  = 4'd7;
  localparam logic [3:0] SER_IDX_LAST  = 4'd15;

  localparam int unsigned RD_TRIG_BIT    = 4;
  localparam int unsigned RD_NOLIGHT_BIT = 3;

  localparam logic [7:0] SPR_TRANSP = 8'h80;
  localparam logic [7:0] SPR_BEHIND = 8'h40;
  localparam logic [7:0] BG_OPAQUE  = 8'h40;
  localparam logic [5:0] COLOR_MASK = 6'd63;

  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] stamp;
  } hit_t;

endpackage

// ===== hw/rtl/lghd_hit_unit.sv =====
`timescale 1ns / 1ps

module lghd_hit_unit #(
  parameter int unsigned AIM_RADIUS = 4
) (
  input  logic [7:0]                   pixel_x_i,
  input  logic [8:0]                   line_number_i,
  input  logic [7:0]                   bg_pixel_i,
  input  logic [7:0]                   spr_pixel_i,
  input  logic                         spr_present_i,
  input  logic [lghd_pkg::TDIV_W-1:0]  tdiv_i,
  input  logic [lghd_pkg::TIME_W-1:0]  time_base_i,
  input  logic [7:0]                   aim_x_i,
  input  logic [7:0]                   aim_y_i,
  input  logic [63:0]                  bright_mask_i,
  output lghd_pkg::hit_t               hit_o
);

  logic [9:0]                    line_w;
  logic [9:0]                    ay_w;
  logic [9:0]                    x_w;
  logic [9:0]                    ax_w;
  logic [9:0]                    rad_w;
  logic                          in_window;
  logic                          spr_wins;
  logic [7:0]                    color_raw;
  logic [5:0]                    color;
  logic [lghd_pkg::PROD_W-1:0]   prod;
  logic [lghd_pkg::TIME_W-1:0]   quot;

  always_comb begin
    line_w = {1'b0, line_number_i};
    ay_w   = {2'b00, aim_y_i};
    x_w    = {2'b00, pixel_x_i};
    ax_w   = {2'b00, aim_x_i};
    rad_w  = 10'(AIM_RADIUS);
    in_window = (line_w + rad_w >= ay_w) && (line_w <= ay_w + rad_w) &&
                (x_w + rad_w >= ax_w) && (x_w <= ax_w + rad_w);

    spr_wins = spr_present_i && ((spr_pixel_i & lghd_pkg::SPR_TRANSP) == 8'd0) &&
               (((spr_pixel_i & lghd_pkg::SPR_BEHIND) == 8'd0) ||
                ((bg_pixel_i & lghd_pkg::BG_OPAQUE) != 8'd0));
    color_raw = spr_wins ? spr_pixel_i : bg_pixel_i;
    color     = color_raw[5:0] & lghd_pkg::COLOR_MASK;

    // divide by 3 through reciprocal multiply
    prod = lghd_pkg::PROD_W'(tdiv_i) * lghd_pkg::PROD_W'(lghd_pkg::DIV3_MUL);
    quot = lghd_pkg::TIME_W'(prod >> lghd_pkg::DIV3_SHIFT);

    hit_o.hit   = in_window && bright_mask_i[color];
    hit_o.stamp = time_base_i + quot;
  end

endmodule

// ===== hw/rtl/light_gun_hit_detector.sv =====
`timescale 1ns / 1ps

// Light-gun input port. Takes one request per clock unless stalled and
// answers read requests with read_data_o via the input register and the
// result register; other requests only update state. Throughput is one
// request per cycle unless stalled, set by a single processing stage between
// the input and result registers, where the hit time divide-by-3 multiply
// and the 48-bit time add sit. Input stalls only while a read waits behind an
// unaccepted result. Configuration writes take effect on the next request.
module light_gun_hit_detector #(
  parameter int unsigned AIM_RADIUS   = 4,
  parameter int unsigned HOLD_FRAMES  = 5,
  parameter int unsigned LIGHT_WINDOW = 100
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lghd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lghd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       action_i,
  input  logic [7:0]                       pixel_x_i,
  input  logic [8:0]                       line_number_i,
  input  logic [7:0]                       bg_pixel_i,
  input  logic [7:0]                       spr_pixel_i,
  input  logic                             spr_present_i,
  input  logic [31:0]                      line_timestamp_i,
  input  logic [47:0]                      time_base_i,
  input  logic [47:0]                      current_time_i,
  input  logic [7:0]                       aim_x_i,
  input  logic [7:0]                       aim_y_i,
  input  logic [1:0]                       buttons_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [4:0]                       read_data_o
);

  logic                            serial_mode_q;
  logic                            pal_timing_q;
  logic [63:0]                     bright_mask_q;

  logic                            s1_valid_q;
  logic [2:0]                      act_q;
  logic [7:0]                      px_q;
  logic [8:0]                      line_q;
  logic [7:0]                      bg_q;
  logic [7:0]                      spr_q;
  logic                            sprp_q;
  logic [lghd_pkg::TDIV_W-1:0]     tdiv_q;
  logic [47:0]                     tbase_q;
  logic [47:0]                     now_q;
  logic [7:0]                      in_ax_q;
  logic [7:0]                      in_ay_q;
  logic [1:0]                      in_btn_q;

  logic [7:0]                      aim_x_q;
  logic [7:0]                      aim_y_q;
  logic [1:0]                      button_q;
  logic [2:0]                      hold_q;
  logic [2:0]                      hold_d;
  logic [3:0]                      ser_idx_q;
  logic [47:0]                     hit_time_q;
  logic                            seg_hit_q;

  logic                            out_valid_q;
  logic [4:0]                      rd_q;
  logic [4:0]                      rd_d;

  logic                            in_acc;
  logic                            s1_read;
  logic                            s1_go;
  logic [8:0]                      px16;
  logic [32:0]                     clk_sum;
  logic                            light_seen;
  lghd_pkg::hit_t                  hit;

  assign s1_read    = (act_q == lghd_pkg::ACT_READ);
  assign s1_go      = s1_valid_q && !(s1_read && out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  // master clock position of the pixel, pre-divided by 16
  always_comb begin
    px16    = {1'b0, pixel_x_i} + 9'd16;
    clk_sum = {1'b0, line_timestamp_i} + {20'd0, px16, 4'd0} -
              (pal_timing_q ? {24'd0, px16} : 33'd0);
  end

  lghd_hit_unit #(
    .AIM_RADIUS(AIM_RADIUS)
  ) u_hit (
    .pixel_x_i     (px_q),
    .line_number_i (line_q),
    .bg_pixel_i    (bg_q),
    .spr_pixel_i   (spr_q),
    .spr_present_i (sprp_q),
    .tdiv_i        (tdiv_q),
    .time_base_i   (tbase_q),
    .aim_x_i       (aim_x_q),
    .aim_y_i       (aim_y_q),
    .bright_mask_i (bright_mask_q),
    .hit_o         (hit)
  );

  always_comb begin
    light_seen = ({1'b0, hit_time_q} + 49'(LIGHT_WINDOW) >= {1'b0, now_q}) &&
                 !button_q[1];
    hold_d = (hold_q != 3'd0) ? hold_q - 3'd1 : hold_q;
    if ((in_btn_q != 2'd0) && (button_q == 2'd0)) begin
      hold_d = 3'(HOLD_FRAMES);
    end
    rd_d = 5'd0;
    if (serial_mode_q) begin
      if (ser_idx_q == lghd_pkg::SER_IDX_ID) begin
        rd_d[0] = 1'b1;
      end else if (ser_idx_q == lghd_pkg::SER_IDX_LIGHT) begin
        rd_d[0] = light_seen;
      end else if (ser_idx_q == lghd_pkg::SER_IDX_TRIG) begin
        rd_d[0] = (hold_q != 3'd0);
      end
    end else begin
      rd_d[lghd_pkg::RD_TRIG_BIT]    = (hold_q != 3'd0);
      rd_d[lghd_pkg::RD_NOLIGHT_BIT] = !light_seen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serial_mode_q <= 1'b0;
      pal_timing_q  <= 1'b0;
      bright_mask_q <= 64'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lghd_pkg::CFG_SERIAL_MODE: serial_mode_q <= cfg_data_i[0];
        lghd_pkg::CFG_PAL_TIMING:  pal_timing_q  <= cfg_data_i[0];
        lghd_pkg::CFG_BRIGHT_MASK: bright_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q    <= action_i;
      px_q     <= pixel_x_i;
      line_q   <= line_number_i;
      bg_q     <= bg_pixel_i;
      spr_q    <= spr_pixel_i;
      sprp_q   <= spr_present_i;
      tdiv_q   <= clk_sum[32:4];
      tbase_q  <= time_base_i;
      now_q    <= current_time_i;
      in_ax_q  <= aim_x_i;
      in_ay_q  <= aim_y_i;
      in_btn_q <= buttons_i;
    end
  end

  // port state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aim_x_q    <= 8'd0;
      aim_y_q    <= 8'd0;
      button_q   <= 2'd0;
      hold_q     <= 3'd0;
      ser_idx_q  <= 4'd0;
      hit_time_q <= 48'd0;
      seg_hit_q  <= 1'b0;
    end else if (s1_go) begin
      unique case (act_q)
        lghd_pkg::ACT_PIXEL: begin
          if (!seg_hit_q && hit.hit) begin
            hit_time_q <= hit.stamp;
            seg_hit_q  <= 1'b1;
          end
        end
        lghd_pkg::ACT_SEGMENT: seg_hit_q <= 1'b0;
        lghd_pkg::ACT_FRAME: begin
          hold_q   <= hold_d;
          aim_x_q  <= in_ax_q;
          aim_y_q  <= in_ay_q;
          button_q <= in_btn_q;
        end
        lghd_pkg::ACT_STROBE: ser_idx_q <= 4'd0;
        lghd_pkg::ACT_READ: begin
          if (serial_mode_q && (ser_idx_q != lghd_pkg::SER_IDX_LAST)) begin
            ser_idx_q <= ser_idx_q + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_read) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_read) begin
      rd_q <= rd_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rd_q;

endmodule

// ===== hw/rtl/lghd_checker.sv =====
`timescale 1ns / 1ps

module lghd_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic       out_valid_o,
  input  logic       out_stall_i,
  input  logic [4:0] read_data_o
);

  // input only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a stalled result");

  // a fresh result comes from an accepted read request, via the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && (action_i == lghd_pkg::ACT_READ), 2))
    else $error("result without a read request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (read_data_o[2:1] == 2'b00))
    else $error("unused read data bits set");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(read_data_o))
    else $error("stalled result changed");

endmodule

bind light_gun_hit_detector lghd_checker u_lghd_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int AIM_RADIUS         = 4;
  localparam int HOLD_FRAMES        = 5;
  localparam int LIGHT_WINDOW       = 100;
  localparam int WATCHDOG_LIMIT     = 2000;
  localparam int DRAIN_CYCLES       = 4;
  localparam int RANDOM_PER_SETTING = 102;
  localparam logic [47:0] MAX48     = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  act;
    logic [7:0]  pixel_x;
    logic [8:0]  line_number;
    logic [7:0]  bg_pixel;
    logic [7:0]  spr_pixel;
    logic        spr_present;
    logic [31:0] line_timestamp;
    logic [47:0] time_base;
    logic [47:0] current_time;
    logic [7:0]  aim_x;
    logic [7:0]  aim_y;
    logic [1:0]  buttons;
  } req_t;

  typedef struct packed {
    logic                 is_cfg;
    lghd_pkg::cfg_idx_e   cfg_idx;
    logic [63:0]          cfg_data;
    req_t                 req;
    logic                 typed;
    logic [4:0]           typed_val;
  } row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [lghd_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [lghd_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [2:0]                      action_i;
  logic [7:0]                      pixel_x_i;
  logic [8:0]                      line_number_i;
  logic [7:0]                      bg_pixel_i;
  logic [7:0]                      spr_pixel_i;
  logic                            spr_present_i;
  logic [31:0]                     line_timestamp_i;
  logic [47:0]                     time_base_i;
  logic [47:0]                     current_time_i;
  logic [7:0]                      aim_x_i;
  logic [7:0]                      aim_y_i;
  logic [1:0]                      buttons_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [4:0]                      read_data_o;

  // predicted port state
  logic        serial_mode_q;
  logic        pal_q;
  logic [63:0] bright_mask_q;
  logic [7:0]  aim_x_q;
  logic [7:0]  aim_y_q;
  logic [1:0]  btn_q;
  logic [2:0]  hold_q;
  logic [3:0]  ser_idx_q;
  logic [47:0] hit_time_q;
  logic        seg_hit_q;

  logic [4:0]  read_data_q[$];
  row_t        dir_rows[$];
  logic [4:0]  want;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int          in_idle_pct = 9;
  int          out_stall_pct = 80;

  light_gun_hit_detector #(
    .AIM_RADIUS  (AIM_RADIUS),
    .HOLD_FRAMES (HOLD_FRAMES),
    .LIGHT_WINDOW(LIGHT_WINDOW)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .pixel_x_i       (pixel_x_i),
    .line_number_i   (line_number_i),
    .bg_pixel_i      (bg_pixel_i),
    .spr_pixel_i     (spr_pixel_i),
    .spr_present_i   (spr_present_i),
    .line_timestamp_i(line_timestamp_i),
    .time_base_i     (time_base_i),
    .current_time_i  (current_time_i),
    .aim_x_i         (aim_x_i),
    .aim_y_i         (aim_y_i),
    .buttons_i       (buttons_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic compute_read_data(input req_t r, output logic has, output logic [4:0] val);
    int          x;
    int          line;
    int          ax;
    int          ay;
    logic [7:0]  color;
    logic [63:0] sum;
    logic        light;
    has   = 1'b0;
    val   = '0;
    light = ({1'b0, hit_time_q} + 49'(LIGHT_WINDOW) >= {1'b0, r.current_time}) &&
            !btn_q[1];
    case (r.act)
      lghd_pkg::ACT_PIXEL: begin
        x     = r.pixel_x;
        line  = r.line_number;
        ax    = aim_x_q;
        ay    = aim_y_q;
        color = r.bg_pixel;
        if (r.spr_present && !r.spr_pixel[7] && (!r.spr_pixel[6] || r.bg_pixel[6])) begin
          color = r.spr_pixel;
        end
        if (!seg_hit_q && line >= ay - AIM_RADIUS && line <= ay + AIM_RADIUS &&
            x >= ax - AIM_RADIUS && x <= ax + AIM_RADIUS && bright_mask_q[color[5:0]]) begin
          sum = 64'(r.line_timestamp) + 64'(x + 16) * (pal_q ? 64'd15 : 64'd16);
          hit_time_q = 48'(sum / 64'd48 + 64'(r.time_base));
          seg_hit_q  = 1'b1;
        end
      end
      lghd_pkg::ACT_SEGMENT: seg_hit_q = 1'b0;
      lghd_pkg::ACT_FRAME: begin
        if (hold_q != 0) hold_q--;
        if (r.buttons != 0 && btn_q == 0) hold_q = 3'(HOLD_FRAMES);
        aim_x_q = r.aim_x;
        aim_y_q = r.aim_y;
        btn_q   = r.buttons;
      end
      lghd_pkg::ACT_STROBE: ser_idx_q = '0;
      lghd_pkg::ACT_READ: begin
        has = 1'b1;
        if (serial_mode_q) begin
          if (ser_idx_q == lghd_pkg::SER_IDX_ID) val = 5'd1;
          else if (ser_idx_q == lghd_pkg::SER_IDX_LIGHT) val = {4'b0, light};
          else if (ser_idx_q == lghd_pkg::SER_IDX_TRIG) val = {4'b0, hold_q != 0};
          if (ser_idx_q < lghd_pkg::SER_IDX_LAST) ser_idx_q++;
        end else begin
          val[lghd_pkg::RD_TRIG_BIT]    = hold_q != 0;
          val[lghd_pkg::RD_NOLIGHT_BIT] = !light;
        end
      end
      default: ;
    endcase
  endtask

  function automatic req_t random_request();
    req_t r;
    int   pick;
    int   v;
    r.act            = lghd_pkg::ACT_PIXEL;
    r.pixel_x        = 8'($urandom);
    r.line_number    = 9'($urandom_range(261));
    r.bg_pixel       = 8'($urandom);
    r.spr_pixel      = 8'($urandom);
    r.spr_present    = 1'($urandom);
    r.line_timestamp = $urandom;
    r.time_base      = 48'({$urandom, $urandom});
    r.current_time   = 48'({$urandom, $urandom});
    r.aim_x          = 8'($urandom);
    r.aim_y          = 8'($urandom);
    r.buttons        = ($urandom_range(1) == 1) ? 2'($urandom) : 2'b00;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // mostly near the aim point so hits happen
      if ($urandom_range(3) != 0) begin
        r.pixel_x = 8'(int'(aim_x_q) + int'($urandom_range(12)) - 6);
        v = int'(aim_y_q) + int'($urandom_range(12)) - 6;
        if (v >= 0 && v <= 261) r.line_number = 9'(v);
      end
      if ($urandom_range(1) == 1) r.line_timestamp = $urandom_range(1000);
    end else if (pick < 53) begin
      r.act = lghd_pkg::ACT_SEGMENT;
    end else if (pick < 61) begin
      r.act = lghd_pkg::ACT_FRAME;
    end else if (pick < 69) begin
      r.act = lghd_pkg::ACT_STROBE;
    end else if (pick < 98) begin
      r.act = lghd_pkg::ACT_READ;
      v = $urandom_range(9);
      if (v < 6) r.current_time = hit_time_q + 48'($urandom_range(200));
      else if (v < 8) r.current_time = 48'($urandom_range(300));
    end else begin
      r.act = 3'($urandom_range(7, 5));
    end
    return r;
  endfunction

  task automatic send_request(input req_t r, input logic typed, input logic [4:0] typed_val);
    logic       has;
    logic [4:0] val;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    action_i         <= r.act;
    pixel_x_i        <= r.pixel_x;
    line_number_i    <= r.line_number;
    bg_pixel_i       <= r.bg_pixel;
    spr_pixel_i      <= r.spr_pixel;
    spr_present_i    <= r.spr_present;
    line_timestamp_i <= r.line_timestamp;
    time_base_i      <= r.time_base;
    current_time_i   <= r.current_time;
    aim_x_i          <= r.aim_x;
    aim_y_i          <= r.aim_y;
    buttons_i        <= r.buttons;
    in_valid_i       <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    compute_read_data(r, has, val);
    if (typed) val = typed_val;
    if (has) read_data_q.push_back(val);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (read_data_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input lghd_pkg::cfg_idx_e idx, input logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      lghd_pkg::CFG_SERIAL_MODE: serial_mode_q = data[0];
      lghd_pkg::CFG_PAL_TIMING:  pal_q = data[0];
      lghd_pkg::CFG_BRIGHT_MASK: bright_mask_q = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic row_t pixel_row(input logic [7:0] x, input logic [8:0] line,
                                     input logic [7:0] bg, input logic [7:0] spr,
                                     input logic present, input logic [31:0] ts,
                                     input logic [47:0] base);
    row_t r;
    r = '0;
    r.req.act            = lghd_pkg::ACT_PIXEL;
    r.req.pixel_x        = x;
    r.req.line_number    = line;
    r.req.bg_pixel       = bg;
    r.req.spr_pixel      = spr;
    r.req.spr_present    = present;
    r.req.line_timestamp = ts;
    r.req.time_base      = base;
    return r;
  endfunction

  function automatic row_t frame_row(input logic [7:0] ax, input logic [7:0] ay,
                                     input logic [1:0] b);
    row_t r;
    r = '0;
    r.req.act     = lghd_pkg::ACT_FRAME;
    r.req.aim_x   = ax;
    r.req.aim_y   = ay;
    r.req.buttons = b;
    return r;
  endfunction

  function automatic row_t read_row(input logic [47:0] now, input logic typed,
                                    input logic [4:0] val);
    row_t r;
    r = '0;
    r.req.act          = lghd_pkg::ACT_READ;
    r.req.current_time = now;
    r.typed            = typed;
    r.typed_val        = val;
    return r;
  endfunction

  function automatic row_t act_row(input logic [2:0] a);
    row_t r;
    r = '0;
    r.req.act = a;
    return r;
  endfunction

  function automatic row_t cfg_row(input lghd_pkg::cfg_idx_e idx, input logic [63:0] data);
    row_t r;
    r = '0;
    r.is_cfg   = 1'b1;
    r.cfg_idx  = idx;
    r.cfg_data = data;
    return r;
  endfunction

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < out_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (read_data_q.size() == 0) begin
          $display("%0t: unexpected read_data, expected none, actual %h", $time, read_data_o);
          fail_count++;
        end else begin
          want = read_data_q.pop_front();
          if (read_data_o !== want) begin
            $display("%0t: read_data mismatch, expected %h, actual %h", $time, want,
                     read_data_o);
            fail_count++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= lghd_pkg::CFG_SERIAL_MODE;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    action_i         <= lghd_pkg::ACT_PIXEL;
    pixel_x_i        <= '0;
    line_number_i    <= '0;
    bg_pixel_i       <= '0;
    spr_pixel_i      <= '0;
    spr_present_i    <= 1'b0;
    line_timestamp_i <= '0;
    time_base_i      <= '0;
    current_time_i   <= '0;
    aim_x_i          <= '0;
    aim_y_i          <= '0;
    buttons_i        <= '0;
    out_stall_i      <= 1'b0;
    serial_mode_q = 1'b0;
    pal_q         = 1'b0;
    bright_mask_q = '0;
    aim_x_q       = '0;
    aim_y_q       = '0;
    btn_q         = '0;
    hold_q        = '0;
    ser_idx_q     = '0;
    hit_time_q    = '0;
    seg_hit_q     = 1'b0;

    // after reset: hit time zero, so light is seen up to the window
    dir_rows.push_back(read_row(48'd0, 1'b1, 5'h00));
    dir_rows.push_back(read_row(MAX48, 1'b1, 5'h08));
    dir_rows.push_back(act_row(3'd5));
    dir_rows.push_back(act_row(3'd7));
    dir_rows.push_back(cfg_row(lghd_pkg::CFG_BRIGHT_MASK, {64{1'b1}}));
    dir_rows.push_back(frame_row(8'd100, 8'd50, 2'b01));
    dir_rows.push_back(read_row(48'd0, 1'b1, 5'h10));
    // widest timestamp and base, hit time wraps
    dir_rows.push_back(pixel_row(8'd100, 9'd50, 8'h00, 8'h80, 1'b1, 32'hFFFF_FFFF, MAX48));
    // repeated hit in the same segment
    dir_rows.push_back(pixel_row(8'd101, 9'd50, 8'h3F, 8'h00, 1'b1, 32'd0, 48'd0));
    dir_rows.push_back(read_row(MAX48, 1'b0, 5'h00));
    dir_rows.push_back(act_row(lghd_pkg::ACT_SEGMENT));
    dir_rows.push_back(pixel_row(8'd96, 9'd54, 8'h41, 8'h05, 1'b1, 32'd100, 48'd1000));
    dir_rows.push_back(read_row(48'd1100, 1'b0, 5'h00));
    dir_rows.push_back(act_row(lghd_pkg::ACT_SEGMENT));
    dir_rows.push_back(pixel_row(8'd105, 9'd50, 8'h01, 8'h00, 1'b0, 32'd0, 48'd7));
    dir_rows.push_back(pixel_row(8'd100, 9'd45, 8'h01, 8'h00, 1'b0, 32'd0, 48'd7));
    dir_rows.push_back(cfg_row(lghd_pkg::CFG_PAL_TIMING, 64'd1));
    dir_rows.push_back(pixel_row(8'd104, 9'd46, 8'h00, 8'h45, 1'b1, 32'd4800, 48'd0));
    dir_rows.push_back(read_row(48'd200, 1'b0, 5'h00));
    // trigger aimed offscreen: never light
    dir_rows.push_back(frame_row(8'd0, 8'd0, 2'b10));
    dir_rows.push_back(read_row(48'd0, 1'b1, 5'h18));
    dir_rows.push_back(cfg_row(lghd_pkg::CFG_SERIAL_MODE, 64'd1));
    dir_rows.push_back(act_row(lghd_pkg::ACT_STROBE));
    dir_rows.push_back(read_row(48'd0, 1'b1, 5'h00));
    dir_rows.push_back(read_row(48'd0, 1'b1, 5'h00));
    dir_rows.push_back(read_row(48'd0, 1'b1, 5'h00));
    dir_rows.push_back(read_row(48'd0, 1'b1, 5'h00));
    dir_rows.push_back(read_row(48'd0, 1'b1, 5'h01));
    dir_rows.push_back(read_row(48'd0, 1'b1, 5'h00));
    dir_rows.push_back(read_row(48'd0, 1'b0, 5'h00));
    dir_rows.push_back(read_row(48'd0, 1'b0, 5'h00));
    dir_rows.push_back(frame_row(8'd255, 8'd255, 2'b11));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_data);
      end else begin
        send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].typed_val);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct   = (ph == 0) ? 9 : (ph == 1) ? 80 : 0;
      out_stall_pct = (ph == 0) ? 80 : (ph == 1) ? 9 : 0;
      for (int s = 0; s < 4; s++) begin
        wait_idle();
        write_reg(lghd_pkg::CFG_SERIAL_MODE, 64'(s[0]));
        write_reg(lghd_pkg::CFG_PAL_TIMING, 64'(s[0] ^ s[1]));
        write_reg(lghd_pkg::CFG_BRIGHT_MASK, (s == 0) ? {64{1'b1}} : (s == 2) ? 64'd0 :
                                             {$urandom, $urandom});
        repeat (RANDOM_PER_SETTING) send_request(random_request(), 1'b0, 5'd0);
      end
    end

    wait_idle();
    if (read_data_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== light_gun_hit_detector.f =====
hw/rtl/lghd_pkg.sv
hw/rtl/lghd_hit_unit.sv
hw/rtl/light_gun_hit_detector.sv
hw/rtl/lghd_checker.sv
sim/tb.sv
